@@ design/sse_pkg.sv @@
`default_nettype none

package sse_pkg;

  localparam int BYTE_W      = 8;
  localparam int OAM_DEPTH   = 256;
  localparam int OAM_ADDR_W  = 8;
  localparam int ENTRY_BITS  = 6;
  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_DATA_W  = 32;

  // Command codes carried in the opcode field.
  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_EVAL  = 2'd1;
  localparam logic [1:0] OP_EMIT  = 2'd2;

  // Configuration register indexes (byte address bit 2).
  localparam logic REG_TALL_SPRITES = 1'b0;
  localparam logic REG_PATTERN_BANK = 1'b1;

  // OAM entry layout and sprite geometry.
  localparam logic [1:0] BYTE_Y    = 2'd0;
  localparam int ATTR_BEHIND_BIT   = 5;
  localparam logic [8:0] SHORT_HEIGHT = 9'd8;
  localparam logic [8:0] TALL_HEIGHT  = 9'd16;
  localparam logic [8:0] LINE_WIDTH   = 9'd256;
  localparam logic [7:0] LAST_FULL_X  = 8'd248;
  localparam logic [3:0] TILE_WIDTH   = 4'd8;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] oam_address;
    logic [7:0] oam_data;
    logic [7:0] scanline;
    logic       layer_select;
  } in_item_t;

  typedef struct packed {
    logic [3:0] sprite_count;
    logic       overflow_flag;
    logic       descriptor_valid;
    logic [7:0] tile_number;
    logic       bank_high;
    logic [2:0] fine_row;
    logic [1:0] palette_number;
    logic [7:0] x_position;
    logic [3:0] visible_pixels;
    logic       is_sprite_zero;
    logic       last;
  } result_item_t;

endpackage

`default_nettype wire

@@ design/sprite_scanline_evaluator_top.sv @@
`default_nettype none
// Sprite scanline evaluator.
// Commands enter on the item channel (item_valid / item_stall / item) and results
// leave on the result channel (result_valid / result_stall / result). An OAM byte
// write gives no result. An evaluate command reads the Y byte of every sprite
// entry through the single OAM read port, one entry per cycle, and gives one
// result. An emit command fetches the four bytes of each kept slot through the
// same port; it gives one result per matching slot (or one empty result), the
// final one marked by last. The block takes one command at a time: item_stall is
// high while a command is being worked on. A finished result waits in the output
// register; a held result_stall only delays the next result, and OAM writes are
// still accepted while a result waits. Reset clears the slot count, the overflow
// flag, the current line, both configuration registers and the output valid
// flag; OAM contents are not cleared. Configuration registers sit on an APB port
// at byte addresses 0 (tall_sprites) and 4 (pattern_bank_high).
module sprite_scanline_evaluator_top #(
  parameter int SPRITE_ENTRIES = 64,
  parameter int LINE_SLOTS     = 8
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                item_valid,
  output logic                                item_stall,
  input  sse_pkg::in_item_t                   item,
  output logic                                result_valid,
  input  logic                                result_stall,
  output sse_pkg::result_item_t               result,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [sse_pkg::CFG_ADDR_W-1:0]      paddr,
  input  logic [sse_pkg::CFG_DATA_W-1:0]      pwdata,
  output logic [sse_pkg::CFG_DATA_W-1:0]      prdata,
  output logic                                pready
);

  import sse_pkg::*;

  localparam int CNT_W      = $clog2(SPRITE_ENTRIES + 1);
  localparam int ENTRY_W    = $clog2(SPRITE_ENTRIES);
  localparam int SLOT_CNT_W = $clog2(LINE_SLOTS + 1);
  localparam int SLOT_IDX_W = (LINE_SLOTS > 1) ? $clog2(LINE_SLOTS) : 1;
  localparam logic [CNT_W-1:0]      ENTRIES_CNT = CNT_W'(SPRITE_ENTRIES);
  localparam logic [SLOT_CNT_W-1:0] SLOTS_CNT   = SLOT_CNT_W'(LINE_SLOTS);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_FETCH,
    S_DECIDE,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic [7:0] tile_number;
    logic       bank_high;
    logic [2:0] fine_row;
    logic [1:0] palette_number;
    logic [7:0] x_position;
    logic [3:0] visible_pixels;
    logic       is_sprite_zero;
  } desc_t;

  state_t state;

  logic tall_sprites;
  logic pattern_bank_high;

  logic [ENTRY_BITS-1:0] slot_entries [LINE_SLOTS];
  logic [SLOT_CNT_W-1:0] slot_count;
  logic                  overflow_sticky;
  logic [7:0]            current_line;

  logic [CNT_W-1:0]      issue_idx;
  logic                  chk_pend;
  logic [ENTRY_BITS-1:0] chk_entry;

  logic [SLOT_CNT_W-1:0] emit_idx;
  logic [SLOT_CNT_W-1:0] emit_idx_next;
  logic [2:0]            fetch_ph;
  logic                  layer;
  logic [7:0]            spr_y;
  logic [7:0]            spr_tile;
  logic [7:0]            spr_attr;
  logic [7:0]            spr_x;
  logic                  have_pend;
  desc_t                 pend;
  desc_t                 desc;

  logic                  item_acc;
  logic                  out_free;
  logic                  ram_we;
  logic [OAM_ADDR_W-1:0] ram_raddr;
  logic [BYTE_W-1:0]     ram_rdata;
  logic [ENTRY_BITS-1:0] eval_entry;
  logic [ENTRY_BITS-1:0] emit_entry;
  logic [8:0]            span_end;
  logic                  in_span;
  logic [7:0]            row;
  logic                  bottom;
  logic [8:0]            visible_full;
  logic                  match;
  logic                  decide_go;
  result_item_t          pend_out;
  logic                  cfg_write;

  assign item_stall = (state != S_IDLE);
  assign item_acc   = item_valid && !item_stall;
  assign out_free   = !result_valid || !result_stall;
  assign ram_we     = item_acc && (item.opcode == OP_WRITE);

  assign eval_entry    = ENTRY_BITS'(issue_idx[ENTRY_W-1:0]);
  assign emit_entry    = slot_entries[emit_idx[SLOT_IDX_W-1:0]];
  assign emit_idx_next = emit_idx + 1'b1;

  always_comb begin
    unique case (state)
      S_EVAL:  ram_raddr = {eval_entry, BYTE_Y};
      S_FETCH: ram_raddr = {emit_entry, fetch_ph[1:0]};
      default: ram_raddr = '0;
    endcase
  end

  sse_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (OAM_DEPTH)
  ) u_oam (
    .clk   (clk),
    .we    (ram_we),
    .waddr (item.oam_address),
    .wdata (item.oam_data),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Span test: the sum is kept at nine bits so a sprite near the
  // bottom does not wrap around to the top lines.
  assign span_end = {1'b0, ram_rdata} + (tall_sprites ? TALL_HEIGHT : SHORT_HEIGHT);
  assign in_span  = ({1'b0, current_line} >= {1'b0, ram_rdata}) &&
                    ({1'b0, current_line} < span_end);

  assign row          = current_line - spr_y;
  assign bottom       = |row[7:3];
  assign visible_full = LINE_WIDTH - {1'b0, spr_x};
  assign match        = (spr_attr[ATTR_BEHIND_BIT] == layer);

  always_comb begin
    if (tall_sprites) begin
      desc.tile_number = {spr_tile[7:1], bottom};
      desc.bank_high   = spr_tile[0];
    end else begin
      desc.tile_number = spr_tile + {7'b0, bottom};
      desc.bank_high   = pattern_bank_high;
    end
    desc.fine_row       = row[2:0];
    desc.palette_number = spr_attr[1:0];
    desc.x_position     = spr_x;
    desc.visible_pixels = (spr_x > LAST_FULL_X) ? visible_full[3:0] : TILE_WIDTH;
    desc.is_sprite_zero = (emit_entry == '0);
  end

  // A matching descriptor is held back one slot so the final one can carry last.
  assign decide_go = !match || !have_pend || out_free;

  always_comb begin
    pend_out.sprite_count     = 4'(slot_count);
    pend_out.overflow_flag    = overflow_sticky;
    pend_out.descriptor_valid = 1'b1;
    pend_out.tile_number      = pend.tile_number;
    pend_out.bank_high        = pend.bank_high;
    pend_out.fine_row         = pend.fine_row;
    pend_out.palette_number   = pend.palette_number;
    pend_out.x_position       = pend.x_position;
    pend_out.visible_pixels   = pend.visible_pixels;
    pend_out.is_sprite_zero   = pend.is_sprite_zero;
    pend_out.last             = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      slot_count      <= '0;
      overflow_sticky <= 1'b0;
      current_line    <= '0;
      result_valid    <= 1'b0;
      have_pend       <= 1'b0;
    end else begin
      if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (item_acc) begin
            case (item.opcode)
              OP_EVAL: begin
                current_line <= item.scanline;
                slot_count   <= '0;
                issue_idx    <= '0;
                chk_pend     <= 1'b0;
                state        <= S_EVAL;
              end
              OP_EMIT: begin
                layer     <= item.layer_select;
                emit_idx  <= '0;
                fetch_ph  <= '0;
                have_pend <= 1'b0;
                state     <= (slot_count == '0) ? S_FINISH : S_FETCH;
              end
              default: begin
              end
            endcase
          end
        end
        S_EVAL: begin
          if (issue_idx != ENTRIES_CNT) begin
            issue_idx <= issue_idx + 1'b1;
          end
          chk_pend  <= (issue_idx != ENTRIES_CNT);
          chk_entry <= eval_entry;
          if (chk_pend && in_span) begin
            if (slot_count < SLOTS_CNT) begin
              slot_entries[slot_count[SLOT_IDX_W-1:0]] <= chk_entry;
              slot_count <= slot_count + 1'b1;
            end else begin
              overflow_sticky <= 1'b1;
            end
          end
          if ((issue_idx == ENTRIES_CNT) && !chk_pend) begin
            have_pend <= 1'b0;
            state     <= S_FINISH;
          end
        end
        S_FETCH: begin
          fetch_ph <= fetch_ph + 1'b1;
          case (fetch_ph)
            3'd1: spr_y    <= ram_rdata;
            3'd2: spr_tile <= ram_rdata;
            3'd3: spr_attr <= ram_rdata;
            3'd4: begin
              spr_x <= ram_rdata;
              state <= S_DECIDE;
            end
            default: begin
            end
          endcase
        end
        S_DECIDE: begin
          if (decide_go) begin
            if (match) begin
              if (have_pend) begin
                result       <= pend_out;
                result_valid <= 1'b1;
              end
              pend      <= desc;
              have_pend <= 1'b1;
            end
            emit_idx <= emit_idx_next;
            fetch_ph <= '0;
            state    <= (emit_idx_next == slot_count) ? S_FINISH : S_FETCH;
          end
        end
        S_FINISH: begin
          if (out_free) begin
            if (have_pend) begin
              result      <= pend_out;
              result.last <= 1'b1;
            end else begin
              result               <= '0;
              result.sprite_count  <= 4'(slot_count);
              result.overflow_flag <= overflow_sticky;
              result.last          <= 1'b1;
            end
            result_valid <= 1'b1;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      tall_sprites      <= 1'b0;
      pattern_bank_high <= 1'b0;
    end else if (cfg_write) begin
      unique case (paddr[2])
        REG_TALL_SPRITES: tall_sprites      <= pwdata[0];
        REG_PATTERN_BANK: pattern_bank_high <= pwdata[0];
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_TALL_SPRITES: prdata = {31'b0, tall_sprites};
      REG_PATTERN_BANK: prdata = {31'b0, pattern_bank_high};
    endcase
  end

endmodule

`default_nettype wire

@@ design/sse_ram.sv @@
`default_nettype none

module sse_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire
